@@ design/websocket_frame_deframer_macros.svh @@
// ---------------------------------------------------------------------------
// websocket_frame_deframer assertion macros
// Shared concurrent assertion forms for the deframer modules.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define WSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, masked during reset.
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ design/wsd_pkg.sv @@
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsd_pkg;

  // Width kept for payload length; longer extended lengths wrap.
  localparam int LEN_BITS = 64;

  localparam logic [3:0] OPCODE_MASK = 4'hF;
  localparam logic [3:0] OP_CONT     = 4'h0;
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_BINARY   = 4'h2;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;
  localparam logic [3:0] OP_PONG     = 4'hA;

  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_EMPTY = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_PING  = 3'd3,
    KIND_PONG  = 3'd4,
    KIND_BAD   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       masked;
    logic       last;
  } result_t;

endpackage

@@ design/wsd_in_reg.sv @@
// ---------------------------------------------------------------------------
// wsd_in_reg
// Input byte register; holds a request while the parser is stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import wsd_pkg::*;

  assign in_stall = byte_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_data <= in_byte;
    end
  end

endmodule

@@ design/wsd_parser.sv @@
// ---------------------------------------------------------------------------
// wsd_parser
// Frame header parser, length/key tracking and payload unmasking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "websocket_frame_deframer_macros.svh"

module wsd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic [7:0]      byte_data,
  input  logic            advance,
  output logic            res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  phase_t              phase, phase_next;
  logic [7:0]          first_header, first_header_next;
  logic                mask_present, mask_present_next;
  logic [3:0]          ext_len_count, ext_len_count_next;
  logic [LEN_BITS-1:0] remaining, remaining_next;
  logic [LEN_BITS-1:0] remaining_dec;
  logic [31:0]         mask_key, mask_key_next;
  logic [1:0]          key_index, key_index_next;
  logic [1:0]          key_sel;
  logic                halted, halted_next;
  logic                after_len, start_pay, finish;
  logic [6:0]          len7;
  logic [3:0]          ext_dec;
  logic                step;

  function automatic kind_t end_kind(input logic [3:0] op);
    kind_t k;
    case (op)
      OP_CONT, OP_TEXT, OP_BINARY: k = KIND_EMPTY;
      OP_CLOSE:                    k = KIND_CLOSE;
      OP_PING:                     k = KIND_PING;
      OP_PONG:                     k = KIND_PONG;
      default:                     k = KIND_BAD;
    endcase
    return k;
  endfunction

  assign step          = byte_valid && advance;
  assign len7          = byte_data[6:0];
  assign ext_dec       = (ext_len_count != 4'd0) ? ext_len_count - 4'd1 : ext_len_count;
  assign remaining_dec = (remaining != '0) ? remaining - LEN_BITS'(1) : remaining;
  // key byte 0 is the most significant byte of the key
  assign key_sel       = 2'd3 - key_index;

  always_comb begin
    phase_next         = phase;
    first_header_next  = first_header;
    mask_present_next  = mask_present;
    ext_len_count_next = ext_len_count;
    remaining_next     = remaining;
    mask_key_next      = mask_key;
    key_index_next     = key_index;
    halted_next        = halted;
    after_len          = 1'b0;
    start_pay          = 1'b0;
    finish             = 1'b0;
    res_valid          = 1'b0;
    res.kind           = KIND_BYTE;
    res.data           = 8'h00;
    res.last           = 1'b0;

    if (!halted) begin
      unique case (phase)
        PH_HDR2: begin
          mask_present_next = byte_data[7];
          if (len7 == LEN7_EXT16) begin
            remaining_next     = '0;
            ext_len_count_next = EXT16_BYTES;
            phase_next         = PH_EXT;
          end else if (len7 == LEN7_EXT64) begin
            remaining_next     = '0;
            ext_len_count_next = EXT64_BYTES;
            phase_next         = PH_EXT;
          end else begin
            remaining_next = LEN_BITS'(len7);
            after_len      = 1'b1;
          end
        end
        PH_EXT: begin
          remaining_next     = {remaining[LEN_BITS-9:0], byte_data};
          ext_len_count_next = ext_dec;
          after_len          = (ext_dec == 4'd0);
        end
        PH_KEY: begin
          mask_key_next  = {mask_key[23:0], byte_data};
          key_index_next = key_index + 2'd1;
          start_pay      = (key_index == 2'd3);
        end
        PH_PAY: begin
          remaining_next = remaining_dec;
          if (first_header[3:0] > OP_BINARY) begin
            // control or unknown frame: payload dropped
            finish = (remaining_dec == '0);
          end else begin
            key_index_next = key_index + 2'd1;
            res_valid      = 1'b1;
            res.data       = mask_present ? byte_data ^ mask_key[key_sel*8 +: 8] : byte_data;
            if (remaining_dec == '0) begin
              res.last   = 1'b1;
              phase_next = PH_HDR1;
            end
          end
        end
        default: begin
          first_header_next = byte_data;
          phase_next        = PH_HDR2;
        end
      endcase

      if (after_len) begin
        if (mask_present_next) begin
          mask_key_next  = '0;
          key_index_next = 2'd0;
          phase_next     = PH_KEY;
        end else begin
          start_pay = 1'b1;
        end
      end

      if (start_pay) begin
        key_index_next = 2'd0;
        if (remaining_next == '0) begin
          finish = 1'b1;
        end else begin
          phase_next = PH_PAY;
        end
      end

      if (finish) begin
        res_valid  = 1'b1;
        res.kind   = end_kind(first_header_next[3:0]);
        res.last   = 1'b1;
        phase_next = PH_HDR1;
        if (res.kind == KIND_BAD) begin
          halted_next = 1'b1;
        end
      end
    end

    res.opcode = first_header_next[3:0] & OPCODE_MASK;
    res.fin    = first_header_next[7];
    res.masked = mask_present_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR1;
      first_header  <= 8'h00;
      mask_present  <= 1'b0;
      ext_len_count <= 4'd0;
      remaining     <= '0;
      mask_key      <= '0;
      key_index     <= 2'd0;
      halted        <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      first_header  <= first_header_next;
      mask_present  <= mask_present_next;
      ext_len_count <= ext_len_count_next;
      remaining     <= remaining_next;
      mask_key      <= mask_key_next;
      key_index     <= key_index_next;
      halted        <= halted_next;
    end
  end

  `WSD_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted)
  `WSD_ASSERT_IMPLY(a_halt_quiet, clk, rst, halted, !res_valid)
  `WSD_ASSERT_NEXT(a_bad_halts, clk, rst, step && res_valid && res.kind == KIND_BAD, halted)

endmodule

@@ design/wsd_out_reg.sv @@
// ---------------------------------------------------------------------------
// wsd_out_reg
// Result register; frees the parser whenever it is empty or being drained.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic             res_valid,
  input  wsd_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_res
);
  import wsd_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= byte_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

endmodule

@@ design/websocket_frame_deframer.sv @@
// ---------------------------------------------------------------------------
// websocket_frame_deframer
// Received WebSocket frame parser with payload unmasking.
// ---------------------------------------------------------------------------
// Takes one stream byte per clock while the result side does not stall, and gives
// at most one result per byte. Each result reaches the outputs through a byte
// register that feeds the header/length/key parser, whose combinational update
// (bounded by the 64-bit length decrement and zero test) lands in a result
// register. A byte can be taken every cycle while results are drained; a stall
// on the result side holds both registers and reaches in_stall in the same
// cycle. An unknown opcode gives a bad-opcode event at the end of its frame,
// after which all bytes are taken and dropped until reset.
`timescale 1ns / 1ps

`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_kind,
  output logic [7:0] out_byte,
  output logic [3:0] frame_opcode,
  output logic       fin_flag,
  output logic       was_masked,
  output logic       frame_last
);
  import wsd_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  wsd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign event_kind   = out_res.kind;
  assign out_byte     = out_res.data;
  assign frame_opcode = out_res.opcode;
  assign fin_flag     = out_res.fin;
  assign was_masked   = out_res.masked;
  assign frame_last   = out_res.last;

  `WSD_ASSERT_IMPLY(a_event_is_last, clk, rst, out_valid && out_res.kind != KIND_BYTE, frame_last)
  `WSD_ASSERT_IMPLY(a_event_no_data, clk, rst, out_valid && out_res.kind != KIND_BYTE, out_byte == 8'h00)

endmodule
